@@ design/mpq_pkg.sv @@
// Package with shared types and codes for the max priority queue.
`timescale 1ns / 1ps
`default_nettype none
package mpq_pkg;
    localparam int VALUE_W = 7;
    localparam int COUNT_W = 6;
    localparam int STATUS_W = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_MOVE,
        S_DONE
    } state_t;
endpackage
`default_nettype wire

@@ design/mpq_heap.sv @@
// Heap value store: a single synchronous RAM with a registered read.
`timescale 1ns / 1ps
`default_nettype none
module mpq_heap #(
    parameter int DEPTH = 32,
    parameter int AW = 5
) (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               wr_addr,
    input  wire logic [mpq_pkg::VALUE_W-1:0] wr_data,
    input  wire logic [AW-1:0]               rd_addr,
    output logic      [mpq_pkg::VALUE_W-1:0] rd_data
);
    logic [mpq_pkg::VALUE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

@@ design/max_priority_queue_top.sv @@
// Top level of the max priority queue: control sequencer, scan and output register.
//
// Input transfers on s_axis carry an operation: mode 0 inserts item_value,
// mode 1 extracts the largest stored value. Each input transfer produces one
// output transfer on m_axis with the removed value, a valid flag, a status
// code and the entry count after the operation.
// Values live in one single-port-write, single-read RAM with a registered read.
// An insert writes at the tail. An extract scans all stored entries through
// the RAM read port, one per cycle, then moves the tail entry into the hole
// of the maximum.
// Reset empties the queue at once by clearing the count; RAM contents are not
// cleared because entries at or above the count are never used.
// When the receiver stalls, the result waits in the output register and no
// new item is accepted until it has been transferred.
`timescale 1ns / 1ps
`default_nettype none
module max_priority_queue_top #(
    parameter int CAPACITY = 32
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,  // [6:0] item_value, [7] zero
    input  wire logic       s_axis_tuser,  // [0] mode
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [15:0]     m_axis_tdata   // [6:0] taken_value, [7] taken_valid,
                                           // [9:8] status, [15:10] entry_count
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);
    localparam int VW = mpq_pkg::VALUE_W;

    mpq_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;        // next address issued in the scan
    logic [CW-1:0] chk_reg, chk_next;        // address of data now on rd_data
    logic [AW-1:0] best_reg, best_next;
    logic [VW-1:0] bval_reg, bval_next;
    logic [15:0] out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [VW-1:0] wr_data, rd_data;

    mpq_heap #(.DEPTH(CAPACITY), .AW(AW)) u_heap (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    assign s_axis_tready = (state_reg == mpq_pkg::S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_reg;

    function automatic logic [15:0] pack(logic [VW-1:0] v, logic tv,
                                         mpq_pkg::status_t st, logic [CW-1:0] c);
        logic [CW+5:0] cw;
        cw = (CW+6)'(c);
        return {cw[5:0], st, tv, v};
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mpq_pkg::S_IDLE;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        chk_reg <= chk_next;
        best_reg <= best_next;
        bval_reg <= bval_next;
        out_reg <= out_next;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next = idx_reg;
        chk_next = chk_reg;
        best_next = best_reg;
        bval_next = bval_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        wr_en = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = s_axis_tdata[VW-1:0];
        rd_addr = idx_reg[AW-1:0];
        case (state_reg)
            mpq_pkg::S_IDLE:
            begin
                rd_addr = '0;
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (!s_axis_tuser)
                    begin
                        if (count_reg >= CAP)
                        begin
                            out_next = pack('0, 1'b0, mpq_pkg::ST_FULL, count_reg);
                        end
                        else
                        begin
                            wr_en = 1'b1;
                            count_next = count_reg + 1'b1;
                            out_next = pack('0, 1'b0, mpq_pkg::ST_OK, count_next);
                        end
                        out_valid_next = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        out_next = pack('0, 1'b0, mpq_pkg::ST_EMPTY, count_reg);
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = CW'(1);
                        chk_next = '0;
                        best_next = '0;
                        bval_next = '0;
                        state_next = mpq_pkg::S_SCAN;
                    end
                end
            end
            mpq_pkg::S_SCAN:
            begin
                // rd_data holds entry chk_reg; the first always wins
                if (chk_reg == '0 || rd_data > bval_reg)
                begin
                    best_next = chk_reg[AW-1:0];
                    bval_next = rd_data;
                end
                chk_next = idx_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == count_reg)
                begin
                    rd_addr = AW'(count_reg - 1'b1);
                    state_next = mpq_pkg::S_MOVE;
                end
            end
            mpq_pkg::S_MOVE:
            begin
                // rd_data holds the tail entry; fill the hole with it
                wr_en = 1'b1;
                wr_addr = best_reg;
                wr_data = rd_data;
                count_next = count_reg - 1'b1;
                out_next = pack(bval_reg, 1'b1, mpq_pkg::ST_OK, count_next);
                out_valid_next = 1'b1;
                state_next = mpq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mpq_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the max priority queue: directed and random insert/extract traffic.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    localparam int CAP = 32;
    localparam int WATCHDOG_LIMIT = 20000;

    // Result fields as they travel on the master side.
    typedef struct packed {
        logic [mpq_pkg::COUNT_W-1:0] entry_count;
        mpq_pkg::status_t            status;
        logic                        taken_valid;
        logic [mpq_pkg::VALUE_W-1:0] taken_value;
    } queue_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    max_priority_queue_top #(.CAPACITY(CAP)) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Shadow copy of the queue contents, used to predict each result.
    logic [mpq_pkg::VALUE_W-1:0] shadow_values[$];
    queue_result_t               pending_results[$];

    int sender_idle_pct;
    int receiver_idle_pct;
    int failures;
    int quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Computes the expected result of one operation and updates the shadow queue.
    function automatic queue_result_t predict_queue_op(logic mode, logic [6:0] value);
        queue_result_t res;
        int            best;
        res = '0;
        res.status = mpq_pkg::ST_OK;
        if (mode == 1'b0)
        begin
            if (shadow_values.size() >= CAP)
                res.status = mpq_pkg::ST_FULL;
            else
                shadow_values = {shadow_values, value};
        end
        else if (shadow_values.size() == 0)
        begin
            res.status = mpq_pkg::ST_EMPTY;
        end
        else
        begin
            best = 0;
            for (int k = 1; k < shadow_values.size(); k++)
                if (shadow_values[k] > shadow_values[best])
                    best = k;
            res.taken_value = shadow_values[best];
            res.taken_valid = 1'b1;
            shadow_values.delete(best);
        end
        res.entry_count = mpq_pkg::COUNT_W'(shadow_values.size());
        return res;
    endfunction

    // Sends one operation, with a random idle gap before it, and records its expectation.
    // Valid stays high after the transfer; the block has already dropped tready then,
    // and the next call either lowers it or drives the next operation; wait_drained lowers it.
    task automatic send_op(logic mode, logic [6:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, value};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_results = {pending_results, predict_queue_op(mode, value)};
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Receiver stalls at random; each accepted transfer is compared with the oldest expectation.
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);

    always @(posedge clk)
    begin
        queue_result_t got;
        queue_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = queue_result_t'(m_axis_tdata);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.taken_value !== want.taken_value)
                begin
                    $display("%0t: taken_value expected %0d actual %0d",
                             $time, want.taken_value, got.taken_value);
                    failures++;
                end
                if (got.taken_valid !== want.taken_valid)
                begin
                    $display("%0t: taken_valid expected %0d actual %0d",
                             $time, want.taken_valid, got.taken_valid);
                    failures++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    failures++;
                end
                if (got.entry_count !== want.entry_count)
                begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, got.entry_count);
                    failures++;
                end
            end
        end
    end

    // Watchdog: any cycle with a transfer on either side restarts the count.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Empty-queue extract, full-queue insert, field extremes and duplicate maxima.
    task automatic test_directed();
        send_op(1'b1, 7'd0);
        send_op(1'b0, 7'd0);
        send_op(1'b0, 7'd127);
        send_op(1'b0, 7'd99);
        send_op(1'b0, 7'd99);
        send_op(1'b1, 7'h7F);
        send_op(1'b1, 7'd0);
        send_op(1'b1, 7'd0);
        send_op(1'b1, 7'd0);
        send_op(1'b1, 7'd0);
        for (int k = 0; k < CAP + 2; k++)
            send_op(1'b0, 7'($urandom_range(127)));
        for (int k = 0; k < 3; k++)
            send_op(1'b1, 7'h55);
    endtask

    // Random traffic; bias toward inserts or extracts sweeps the fill level end to end.
    task automatic test_random(int count);
        int extract_pct;
        extract_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                extract_pct = (n / 60) % 3 == 0 ? 20 : ((n / 60) % 3 == 1 ? 80 : 50);
            send_op($urandom_range(99) < extract_pct,
                    ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(99)));
        end
    endtask

    // The sender holds off until every result is back, then carries on.
    task automatic test_drain_pause();
        send_op(1'b0, 7'd42);
        wait_drained();
        send_op(1'b1, 7'd0);
    endtask

    initial
    begin
        failures = 0;
        quiet_cycles = 0;
        sender_idle_pct = 14;
        receiver_idle_pct = 73;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(600);
        test_drain_pause();
        sender_idle_pct = 73;
        receiver_idle_pct = 14;
        test_random(600);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random(700);

        wait_drained();
        repeat (CAP + 10) @(negedge clk);
        if (failures == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
`default_nettype wire

@@ max_priority_queue_top.f @@
design/mpq_pkg.sv
design/mpq_heap.sv
design/max_priority_queue_top.sv
tb/sv/tb.sv
